[design/rle8_pkg.sv]
// ----------------------------------------------------------------------------
// RLE8 encoder package
// Shared widths, register indexes, escape codes and payload types of the
// bitmap RLE8 encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rle8_pkg;

    localparam int PIX_W      = 8;
    localparam int CNT_W      = 8;
    localparam int LW_W       = 16;
    localparam int COL_W      = 16;
    localparam int CMP_W      = ((COL_W > LW_W) ? COL_W : LW_W) + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RUN    = 2'd1;

    localparam logic [LW_W-1:0]  LINE_WIDTH_RST = 16'd1;
    localparam logic [CNT_W-1:0] MAX_RUN_RST    = 8'd127;

    localparam logic [PIX_W-1:0] ESC_EOL = 8'd0;
    localparam logic [PIX_W-1:0] ESC_EOB = 8'd1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int NUM_RES = 4;
    localparam int SEL_A   = 0;
    localparam int SEL_B   = 1;
    localparam int SEL_EOL = 2;
    localparam int SEL_EOB = 3;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             end_of_image;
    } t_pix;

    typedef struct packed {
        logic [CNT_W-1:0] count_byte;
        logic [PIX_W-1:0] data_byte;
        logic             last;
    } t_pair;

    typedef struct packed {
        logic             a_vld;
        logic [CNT_W-1:0] a_cnt;
        logic [PIX_W-1:0] a_val;
        logic             b_vld;
        logic [CNT_W-1:0] b_cnt;
        logic [PIX_W-1:0] b_val;
        logic             eol;
        logic             eob;
    } t_entry;

endpackage

`default_nettype wire

[design/bmp_rle8_encoder_core.sv]
// ----------------------------------------------------------------------------
// Bitmap RLE8 encoder core
// A pixel yields up to four pairs, which pass the queue and then the output register.
// Throughput: one pixel per cycle unless the queue is full, one pair per cycle when ready.
// A four-entry queue between the front end and the emitter absorbs bursts of pairs.
// Reset (synchronous, active low) empties the queue and output stage, closes the run,
// clears the column and returns line width to 1 and maximum run to 127.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_rle8_encoder_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire rle8_pkg::t_pix                  i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output rle8_pkg::t_pair                      o_out_data,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [rle8_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [rle8_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic             push;
    logic             pop;
    logic             empty;
    logic             full;
    logic             pix_accept;
    rle8_pkg::t_entry entry;
    rle8_pkg::t_entry head;

    assign o_in_ready  = !full;
    assign o_cfg_ready = 1'b1;
    assign pix_accept  = i_in_valid && !full;

    rle8_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_pix_accept (pix_accept),
        .i_pix        (i_in_data),
        .o_push       (push),
        .o_entry      (entry)
    );

    rle8_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    rle8_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

[design/rle8_front.sv]
// ----------------------------------------------------------------------------
// RLE8 front end
// Holds the open run, the column and the configuration registers, and turns
// each pixel that closes a pair into one queue entry that lists the pairs it closes.
// ----------------------------------------------------------------------------
`default_nettype none

module rle8_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    input  wire logic [rle8_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [rle8_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_pix_accept,
    input  wire rle8_pkg::t_pix                  i_pix,
    output logic                                 o_push,
    output rle8_pkg::t_entry                     o_entry
);

    logic [rle8_pkg::LW_W-1:0]  r_line_width;
    logic [rle8_pkg::CNT_W-1:0] r_max_run;
    logic [rle8_pkg::PIX_W-1:0] r_run_value, n_run_value;
    logic [rle8_pkg::CNT_W-1:0] r_run_length, n_run_length;
    logic [rle8_pkg::COL_W-1:0] r_column, n_column;

    logic [rle8_pkg::CNT_W-1:0] limit;
    logic                       close_a;
    logic [rle8_pkg::CNT_W-1:0] len_mid;
    logic [rle8_pkg::PIX_W-1:0] val_mid;
    logic [rle8_pkg::CNT_W-1:0] len_new;
    logic [rle8_pkg::CMP_W-1:0] col_inc;
    logic                       row_end;
    logic                       close_b;

    always_comb begin
        limit   = (r_max_run == '0) ? rle8_pkg::CNT_W'(1) : r_max_run;
        close_a = (r_run_length != '0) &&
                  ((i_pix.pixel != r_run_value) || (r_run_length >= limit));
        len_mid = close_a ? '0 : r_run_length;
        val_mid = (len_mid == '0) ? i_pix.pixel : r_run_value;
        len_new = len_mid + rle8_pkg::CNT_W'(1);
        col_inc = rle8_pkg::CMP_W'(r_column) + rle8_pkg::CMP_W'(1);
        row_end = col_inc >= rle8_pkg::CMP_W'(r_line_width);
        close_b = row_end || i_pix.end_of_image;

        n_run_length = close_b ? '0 : len_new;
        n_run_value  = i_pix.end_of_image ? '0 : val_mid;
        n_column     = close_b ? '0 : col_inc[rle8_pkg::COL_W-1:0];

        o_entry.a_vld = close_a;
        o_entry.a_cnt = r_run_length;
        o_entry.a_val = r_run_value;
        o_entry.b_vld = close_b;
        o_entry.b_cnt = len_new;
        o_entry.b_val = val_mid;
        o_entry.eol   = row_end;
        o_entry.eob   = i_pix.end_of_image;
        o_push        = i_pix_accept && (close_a || close_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= rle8_pkg::LINE_WIDTH_RST;
            r_max_run    <= rle8_pkg::MAX_RUN_RST;
            r_run_value  <= '0;
            r_run_length <= '0;
            r_column     <= '0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == rle8_pkg::REG_LINE_WIDTH) begin
                    r_line_width <= i_cfg_data[rle8_pkg::LW_W-1:0];
                end else if (i_cfg_index == rle8_pkg::REG_MAX_RUN) begin
                    r_max_run <= i_cfg_data[rle8_pkg::CNT_W-1:0];
                end
            end
            if (i_pix_accept) begin
                r_run_value  <= n_run_value;
                r_run_length <= n_run_length;
                r_column     <= n_column;
            end
        end
    end

endmodule

`default_nettype wire

[design/rle8_queue.sv]
// ----------------------------------------------------------------------------
// RLE8 entry queue
// A short register queue that carries entries from the front end to the
// pair emitter, so that each side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module rle8_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire rle8_pkg::t_entry  i_entry,
    input  wire logic              i_pop,
    output rle8_pkg::t_entry       o_head,
    output logic                   o_empty,
    output logic                   o_full
);

    rle8_pkg::t_entry r_mem [rle8_pkg::QUEUE_DEPTH];
    logic [rle8_pkg::QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [rle8_pkg::QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [rle8_pkg::QUEUE_CNT_W-1:0] r_count;
    logic                             do_push;
    logic                             do_pop;

    always_comb begin
        o_empty = (r_count == '0);
        o_full  = (r_count == rle8_pkg::QUEUE_CNT_W'(rle8_pkg::QUEUE_DEPTH));
        do_push = i_push && !o_full;
        do_pop  = i_pop && !o_empty;
        o_head  = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + rle8_pkg::QUEUE_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + rle8_pkg::QUEUE_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + rle8_pkg::QUEUE_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - rle8_pkg::QUEUE_CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

[design/rle8_back.sv]
// ----------------------------------------------------------------------------
// RLE8 pair emitter
// Walks the pairs listed in the head entry in order and presents them one
// per cycle, unless the output stalls, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rle8_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rle8_pkg::t_entry  i_head,
    input  wire logic              i_empty,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output rle8_pkg::t_pair        o_out_data
);

    logic [rle8_pkg::NUM_RES-1:0] r_done, n_done;
    logic                         r_out_vld;
    rle8_pkg::t_pair              r_out;
    logic [rle8_pkg::NUM_RES-1:0] flags;
    logic [rle8_pkg::NUM_RES-1:0] pending;
    logic [rle8_pkg::NUM_RES-1:0] sel;
    logic                         load;
    rle8_pkg::t_pair              n_out;

    always_comb begin
        flags                    = '0;
        flags[rle8_pkg::SEL_A]   = i_head.a_vld;
        flags[rle8_pkg::SEL_B]   = i_head.b_vld;
        flags[rle8_pkg::SEL_EOL] = i_head.eol;
        flags[rle8_pkg::SEL_EOB] = i_head.eob;
        pending = i_empty ? '0 : (flags & ~r_done);

        sel   = '0;
        n_out = '0;
        priority if (pending[rle8_pkg::SEL_A]) begin
            sel[rle8_pkg::SEL_A] = 1'b1;
            n_out.count_byte     = i_head.a_cnt;
            n_out.data_byte      = i_head.a_val;
        end else if (pending[rle8_pkg::SEL_B]) begin
            sel[rle8_pkg::SEL_B] = 1'b1;
            n_out.count_byte     = i_head.b_cnt;
            n_out.data_byte      = i_head.b_val;
        end else if (pending[rle8_pkg::SEL_EOL]) begin
            sel[rle8_pkg::SEL_EOL] = 1'b1;
            n_out.data_byte        = rle8_pkg::ESC_EOL;
        end else if (pending[rle8_pkg::SEL_EOB]) begin
            sel[rle8_pkg::SEL_EOB] = 1'b1;
            n_out.data_byte        = rle8_pkg::ESC_EOB;
            n_out.last             = 1'b1;
        end else begin
            sel = '0;
        end

        load  = (pending != '0) && (!r_out_vld || i_out_ready);
        o_pop = load && ((pending & ~sel) == '0);

        if (o_pop) begin
            n_done = '0;
        end else if (load) begin
            n_done = r_done | sel;
        end else begin
            n_done = r_done;
        end

        o_out_valid = r_out_vld;
        o_out_data  = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_done <= n_done;
            if (load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire
